// File: sv/tlpte_pkg.sv
// ----------------------------------------------------------------------------
// tlpte_pkg
// Shared constants, request codes and controller/datapath interface types
// for the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpte_pkg;

    localparam int unsigned DIR_ENTRIES_DEF   = 1024;
    localparam int unsigned TABLE_ENTRIES_DEF = 1024;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned OFF_W    = 12;
    localparam int unsigned FRAME_W  = 20;
    localparam int unsigned PTE_W    = 23;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned DIR_LSB  = 22;
    localparam int unsigned TAB_LSB  = 12;

    localparam int unsigned PTE_PRESENT = 0;
    localparam int unsigned PTE_FRAME_LSB = 3;

    localparam logic [REQ_W-1:0] REQ_MAP_USER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MAP_KERN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNMAP    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_XLAT     = 2'd3;

    typedef struct packed {
        logic accept;
        logic dir_init_wr;
        logic dir_set;
        logic ctr_clr;
        logic ctr_inc;
        logic clear_wr;
        logic entry_wr;
        logic out_load;
    } tlpte_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             in_range;
        logic             dir_present;
        logic             out_free;
        logic             init_last;
        logic             clr_last;
    } tlpte_status_t;

endpackage

// File: sv/tlpte_dp.sv
// ----------------------------------------------------------------------------
// tlpte_dp
// Datapath: request registers, directory and table memories, walk counter
// and the result output register.
// ----------------------------------------------------------------------------
module tlpte_dp #(
    parameter int unsigned DIR_ENTRIES   = tlpte_pkg::DIR_ENTRIES_DEF,
    parameter int unsigned TABLE_ENTRIES = tlpte_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tlpte_pkg::tlpte_cmd_t      cmd,
    output tlpte_pkg::tlpte_status_t   status,
    input  logic [63:0]                s_tdata,   // virt_addr[31:0], phys_addr[63:32]
    input  logic [1:0]                 s_tuser,   // req_type[1:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata    // phys_out[31:0]
);

    localparam int unsigned TAB_DEPTH = DIR_ENTRIES * TABLE_ENTRIES;
    localparam int unsigned DW        = $clog2(DIR_ENTRIES);
    localparam int unsigned TW        = $clog2(TABLE_ENTRIES);
    localparam int unsigned SW        = $clog2(TAB_DEPTH);
    localparam int unsigned MAX_ENT   =
        (DIR_ENTRIES > TABLE_ENTRIES) ? DIR_ENTRIES : TABLE_ENTRIES;
    localparam int unsigned CW        = $clog2(MAX_ENT);

    logic                          dir_mem [DIR_ENTRIES];
    logic [tlpte_pkg::PTE_W-1:0]   tab_mem [TAB_DEPTH];

    logic [tlpte_pkg::REQ_W-1:0]   req_reg;
    logic [tlpte_pkg::ADDR_W-1:0]  virt_reg;
    logic [tlpte_pkg::ADDR_W-1:0]  phys_reg;
    logic                          in_range_reg;
    logic [SW-1:0]                 slot_reg;
    logic [SW-1:0]                 base_reg;
    logic                          dir_rd_reg;
    logic [tlpte_pkg::PTE_W-1:0]   pte_rd_reg;
    logic [CW-1:0]                 ctr_reg;
    logic [CW-1:0]                 ctr_next;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [31:0]                   m_tdata_reg;

    logic [tlpte_pkg::IDX_W-1:0]   d_in;
    logic [tlpte_pkg::IDX_W-1:0]   t_in;
    logic                          in_range_in;
    logic [SW-1:0]                 base_in;
    logic [SW-1:0]                 slot_in;
    logic [DW-1:0]                 dir_wr_addr;
    logic                          dir_wr_en;
    logic [SW-1:0]                 tab_wr_addr;
    logic [tlpte_pkg::PTE_W-1:0]   tab_wr_data;
    logic                          tab_wr_en;
    logic [tlpte_pkg::PTE_W-1:0]   pte_new;
    logic [31:0]                   result;

    assign d_in = s_tdata[tlpte_pkg::DIR_LSB +: tlpte_pkg::IDX_W];
    assign t_in = s_tdata[tlpte_pkg::TAB_LSB +: tlpte_pkg::IDX_W];

    assign in_range_in = ({1'b0, d_in} < (tlpte_pkg::IDX_W + 1)'(DIR_ENTRIES))
                      && ({1'b0, t_in} < (tlpte_pkg::IDX_W + 1)'(TABLE_ENTRIES));
    assign base_in = SW'(d_in[DW-1:0]) * SW'(TABLE_ENTRIES);
    assign slot_in = base_in + SW'(t_in[TW-1:0]);

    assign pte_new = (req_reg == tlpte_pkg::REQ_UNMAP) ? '0 :
                     {phys_reg[tlpte_pkg::ADDR_W-1:tlpte_pkg::OFF_W],
                      (req_reg == tlpte_pkg::REQ_MAP_USER), 1'b1, 1'b1};

    assign dir_wr_en   = cmd.dir_init_wr || cmd.dir_set;
    assign dir_wr_addr = cmd.dir_init_wr ? ctr_reg[DW-1:0]
                                         : virt_reg[tlpte_pkg::DIR_LSB +: DW];

    assign tab_wr_en   = cmd.clear_wr || cmd.entry_wr;
    assign tab_wr_addr = cmd.clear_wr ? (base_reg + SW'(ctr_reg)) : slot_reg;
    assign tab_wr_data = cmd.clear_wr ? '0 : pte_new;

    assign result = ((req_reg == tlpte_pkg::REQ_XLAT) && in_range_reg && dir_rd_reg
                     && pte_rd_reg[tlpte_pkg::PTE_PRESENT])
                    ? {pte_rd_reg[tlpte_pkg::PTE_FRAME_LSB +: tlpte_pkg::FRAME_W],
                       virt_reg[tlpte_pkg::OFF_W-1:0]}
                    : '0;

    always_comb
    begin
        ctr_next = ctr_reg;
        if (cmd.ctr_clr)
        begin
            ctr_next = '0;
        end
        else if (cmd.ctr_inc)
        begin
            ctr_next = ctr_reg + CW'(1);
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            ctr_reg      <= ctr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg      <= s_tuser;
            virt_reg     <= s_tdata[31:0];
            phys_reg     <= s_tdata[63:32];
            in_range_reg <= in_range_in;
            base_reg     <= base_in;
            slot_reg     <= slot_in;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dir_wr_en)
        begin
            dir_mem[dir_wr_addr] <= cmd.dir_set;
        end
        if (cmd.accept)
        begin
            dir_rd_reg <= dir_mem[d_in[DW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_wr_en)
        begin
            tab_mem[tab_wr_addr] <= tab_wr_data;
        end
        if (cmd.accept)
        begin
            pte_rd_reg <= tab_mem[slot_in];
        end
    end

    assign status.req_type    = req_reg;
    assign status.in_range    = in_range_reg;
    assign status.dir_present = dir_rd_reg;
    assign status.out_free    = !m_tvalid_reg || m_tready;
    assign status.init_last   = (ctr_reg == CW'(DIR_ENTRIES - 1));
    assign status.clr_last    = (ctr_reg == CW'(TABLE_ENTRIES - 1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sv/tlpte_ctrl.sv
// ----------------------------------------------------------------------------
// tlpte_ctrl
// Controller: directory clearing after reset, request decode, table clear
// walk on directory allocation and result hand-off.
// ----------------------------------------------------------------------------
module tlpte_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  tlpte_pkg::tlpte_status_t  status,
    output tlpte_pkg::tlpte_cmd_t     cmd
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       is_map;

    assign is_map   = (status.req_type == tlpte_pkg::REQ_MAP_USER)
                   || (status.req_type == tlpte_pkg::REQ_MAP_KERN);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                cmd.dir_init_wr = 1'b1;
                cmd.ctr_inc     = 1'b1;
                if (status.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (status.in_range && is_map && !status.dir_present)
                begin
                    cmd.dir_set = 1'b1;
                    cmd.ctr_clr = 1'b1;
                    state_next  = ST_CLEAR;
                end
                else
                begin
                    cmd.entry_wr = status.in_range && status.dir_present
                                && (is_map || status.req_type == tlpte_pkg::REQ_UNMAP);
                    cmd.out_load = status.out_free;
                    state_next   = status.out_free ? ST_IDLE : ST_RESP;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.ctr_inc  = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.entry_wr = 1'b1;
                cmd.out_load = status.out_free;
                state_next   = status.out_free ? ST_IDLE : ST_RESP;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while output register busy");

    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> (!cmd.accept && !cmd.entry_wr && !cmd.clear_wr))
        else $error("request activity during directory clearing");

    a_clear_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && status.clr_last) |=> (state_reg == ST_WRITE))
        else $error("table clear walk did not end in entry write");

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_LOOK))
        else $error("accepted request not looked up");
`endif

endmodule

// File: sv/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine
// Two-level page table with map user, map kernel, unmap and translate
// requests; one phys_out result per request (zero except for a translate
// that hits). A request is accepted, reading the directory and table
// memories, in the idle state; it is decided and written back in the lookup
// state, and a busy output register holds it in a response state. A map into
// an absent directory slot adds a walk that zeroes that slot's table through
// the table memory's single write port. After reset the directory memory is
// cleared one entry per cycle with s_tready low. A finished result waits in
// the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module two_level_page_table_engine #(
    parameter int unsigned DIR_ENTRIES   = tlpte_pkg::DIR_ENTRIES_DEF,
    parameter int unsigned TABLE_ENTRIES = tlpte_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // virt_addr[31:0], phys_addr[63:32]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // phys_out[31:0]
);

    tlpte_pkg::tlpte_cmd_t    cmd;
    tlpte_pkg::tlpte_status_t status;

    tlpte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tlpte_dp #(
        .DIR_ENTRIES   (DIR_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
